FILE: hw/rtl/lzwce_pkg.sv
// shared types and constants of the lz window copy expander
`default_nettype none

package lzwce_pkg;

    localparam int TOKEN_W  = 9;
    localparam int DIST_W   = 13;
    localparam int BYTE_W   = 8;
    localparam int LANES    = 4;
    localparam int POS_W    = 2;
    localparam int COUNT_W  = 3;
    localparam int LEN_W    = 9;

    localparam logic [TOKEN_W-1:0] TOKEN_LIT_MAX = 9'd255;
    localparam logic [TOKEN_W-1:0] TOKEN_END     = 9'h1FE;
    localparam logic [TOKEN_W-1:0] RUN_BIAS      = 9'd253;
    localparam logic [POS_W-1:0]   POS_LAST_LANE = 2'd3;

    typedef struct packed {
        logic [TOKEN_W-1:0] token;
        logic [DIST_W-1:0]  distance;
    } t_in;

    typedef struct packed {
        logic [BYTE_W-1:0]  byte0;
        logic [BYTE_W-1:0]  byte1;
        logic [BYTE_W-1:0]  byte2;
        logic [BYTE_W-1:0]  byte3;
        logic [COUNT_W-1:0] byte_count;
        logic               last_beat;
        logic               stream_end;
    } t_out;

    // one copied byte arriving from the window read
    typedef struct packed {
        logic             vld;
        logic [POS_W-1:0] pos;
        logic             last;
    } t_arr;

    // a complete single-beat result (literal or end marker)
    typedef struct packed {
        logic vld;
        t_out beat;
    } t_direct;

endpackage

`default_nettype wire

FILE: hw/rtl/lzwce_window_ram.sv
// ring window memory: one write port, one registered read port with write forwarding
`default_nettype none

module lzwce_window_ram #(
    parameter int AW = 13,
    parameter int DW = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_q;
    logic [DW-1:0] r_byp_data;
    logic          r_byp;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q        <= r_mem[i_raddr];
            // same-cycle write to the read address: hand the new byte over
            r_byp      <= i_we && (i_waddr == i_raddr);
            r_byp_data <= i_wdata;
        end
    end

    assign o_rdata = r_byp ? r_byp_data : r_q;

endmodule

`default_nettype wire

FILE: hw/rtl/lzwce_beat_packer.sv
// gathers copied bytes into four-byte beats and holds the output register
`default_nettype none

module lzwce_beat_packer
    import lzwce_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_arr              i_arr,
    input  wire logic [BYTE_W-1:0] i_byte,
    input  wire t_direct           i_direct,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output t_out                   o_out_data
);

    logic [BYTE_W-1:0] r_col [LANES];
    logic              r_out_valid;
    t_out              r_out;
    logic [BYTE_W-1:0] lane [LANES];
    logic              done;
    t_out              run_beat;

    assign done = i_arr.vld && ((i_arr.pos == POS_LAST_LANE) || i_arr.last);

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            if (POS_W'(i) == i_arr.pos) begin
                lane[i] = i_byte;
            end else if (POS_W'(i) < i_arr.pos) begin
                lane[i] = r_col[i];
            end else begin
                lane[i] = '0;
            end
        end
        run_beat.byte0      = lane[0];
        run_beat.byte1      = lane[1];
        run_beat.byte2      = lane[2];
        run_beat.byte3      = lane[3];
        run_beat.byte_count = COUNT_W'(i_arr.pos) + COUNT_W'(1);
        run_beat.last_beat  = i_arr.last;
        run_beat.stream_end = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_arr.vld) begin
            r_col[i_arr.pos] <= i_byte;
        end
        if (done) begin
            r_out <= run_beat;
        end else if (i_direct.vld) begin
            r_out <= i_direct.beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done || i_direct.vld) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

FILE: hw/rtl/lz_window_copy_expander_core.sv
// top level: token sequencer around the ring window and the beat packer
`default_nettype none

// Back end of an LZ77-style decompressor over a ring window of 2**WINDOW_BITS
// bytes. A literal token (0..255) is written to the window and goes out as a
// one-byte beat; token 510 gives one end-of-stream beat with no bytes; token 511
// is taken and dropped. A run token (256..509) copies token-253 bytes starting
// at write position minus distance minus one, overlap allowed, and sends them
// out four per beat with last_beat on the final one. A run holds the input until
// all its bytes are copied: the window has a single read port and copies one
// byte per cycle, stalling while a finished beat waits for the output register
// to be free. The window is not cleared at reset; a run must only reference
// bytes written since reset.
module lz_window_copy_expander_core
    import lzwce_pkg::*;
#(
    parameter int WINDOW_BITS = 13
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_in  i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out      o_out_data
);

    localparam int SUM_W = (WINDOW_BITS > DIST_W) ? WINDOW_BITS : DIST_W;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    t_state                 r_state, n_state;
    logic [WINDOW_BITS-1:0] r_wp, n_wp;
    logic [WINDOW_BITS-1:0] r_src, n_src;
    logic [LEN_W-1:0]       r_len, n_len;
    logic [POS_W-1:0]       r_pos, n_pos;
    logic                   r_pend, n_pend;
    logic [POS_W-1:0]       r_pend_pos, n_pend_pos;
    logic                   r_pend_last, n_pend_last;

    logic [TOKEN_W-1:0]     tok;
    logic                   is_lit, is_end, is_run;
    logic                   in_fire;
    logic                   pend_done;
    logic                   out_free_next;
    logic                   issue;
    logic                   we;
    logic [BYTE_W-1:0]      wdata;
    logic [BYTE_W-1:0]      rdata;
    logic [SUM_W-1:0]       src_sum;
    t_arr                   arr;
    t_direct                direct;

    assign tok    = i_in_data.token;
    assign is_lit = (tok <= TOKEN_LIT_MAX);
    assign is_end = (tok == TOKEN_END);
    assign is_run = !is_lit && (tok < TOKEN_END);

    assign o_in_ready = (r_state == S_IDLE) && !r_pend && (!o_out_valid || i_out_ready);
    assign in_fire    = i_in_valid && o_in_ready;

    // a beat finishing now fills the output register for the next cycle
    assign pend_done     = r_pend && ((r_pend_pos == POS_LAST_LANE) || r_pend_last);
    assign out_free_next = (!o_out_valid || i_out_ready) && !pend_done;

    assign issue = (r_state == S_RUN) && (r_len != '0) &&
                   (!((r_pos == POS_LAST_LANE) || (r_len == LEN_W'(1))) || out_free_next);

    assign we    = r_pend || (in_fire && is_lit);
    assign wdata = r_pend ? rdata : tok[BYTE_W-1:0];

    assign src_sum = SUM_W'(r_wp) - SUM_W'(i_in_data.distance) - SUM_W'(1);

    always_comb begin
        n_state     = r_state;
        n_wp        = we ? r_wp + WINDOW_BITS'(1) : r_wp;
        n_src       = r_src;
        n_len       = r_len;
        n_pos       = r_pos;
        n_pend      = 1'b0;
        n_pend_pos  = r_pend_pos;
        n_pend_last = r_pend_last;
        case (r_state)
            S_IDLE: begin
                if (in_fire && is_run) begin
                    n_src   = src_sum[WINDOW_BITS-1:0];
                    n_len   = tok - RUN_BIAS;
                    n_pos   = '0;
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (issue) begin
                    n_src       = r_src + WINDOW_BITS'(1);
                    n_len       = r_len - LEN_W'(1);
                    n_pos       = r_pos + POS_W'(1);
                    n_pend      = 1'b1;
                    n_pend_pos  = r_pos;
                    n_pend_last = (r_len == LEN_W'(1));
                end else if (r_len == '0) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wp    <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wp    <= n_wp;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_src       <= n_src;
        r_len       <= n_len;
        r_pos       <= n_pos;
        r_pend_pos  <= n_pend_pos;
        r_pend_last <= n_pend_last;
    end

    always_comb begin
        arr.vld  = r_pend;
        arr.pos  = r_pend_pos;
        arr.last = r_pend_last;

        direct.vld             = in_fire && (is_lit || is_end);
        direct.beat.byte0      = is_lit ? tok[BYTE_W-1:0] : '0;
        direct.beat.byte1      = '0;
        direct.beat.byte2      = '0;
        direct.beat.byte3      = '0;
        direct.beat.byte_count = is_lit ? COUNT_W'(1) : '0;
        direct.beat.last_beat  = 1'b1;
        direct.beat.stream_end = is_end;
    end

    lzwce_window_ram #(
        .AW (WINDOW_BITS),
        .DW (BYTE_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_wp),
        .i_wdata (wdata),
        .i_re    (issue),
        .i_raddr (r_src),
        .o_rdata (rdata)
    );

    lzwce_beat_packer u_packer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_arr       (arr),
        .i_byte      (rdata),
        .i_direct    (direct),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

FILE: bench/tb.sv
// self-checking testbench for the lz window copy expander core
`timescale 1ns / 100ps

module tb;
    import lzwce_pkg::*;

    localparam int WIN_BITS    = 13;
    localparam int WIN_BYTES   = 1 << WIN_BITS;
    localparam int RAND_ITEMS  = 210;
    localparam int PARK_AT     = 40;
    localparam int PARK_CYCLES = 600;
    localparam int SETTLE      = 64;
    localparam int LIMIT       = 2000000;

    localparam logic [TOKEN_W-1:0] TOKEN_RUN_MIN = RUN_BIAS + 9'd3;
    localparam logic [TOKEN_W-1:0] TOKEN_RUN_MAX = TOKEN_END - 9'd1;
    localparam logic [TOKEN_W-1:0] TOKEN_NULL    = 9'h1FF;

    typedef struct {
        t_in item;
        bit  drain;
    } t_pending;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    t_in  i_in_data   = '0;
    logic i_out_ready = 1'b0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out_data;

    t_pending token_queue [$];
    t_out     beats_due [$];

    // predictor copy of the ring window
    logic [BYTE_W-1:0]   hist [WIN_BYTES];
    logic [WIN_BITS-1:0] wr_pos = '0;

    int  gen_written = 0;
    int  errors      = 0;
    int  taken_count = 0;
    int  offered     = 0;
    int  cycles      = 0;
    int  src_gap     = 0;
    int  rdy_gap     = 0;
    int  park_left   = 0;
    bit  parked      = 1'b0;
    bit  in_taken    = 1'b0;

    lz_window_copy_expander_core #(
        .WINDOW_BITS(WIN_BITS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    always #2 i_clk = ~i_clk;

    task automatic queue_token(input logic [TOKEN_W-1:0] tok,
                               input logic [DIST_W-1:0] offs, input bit drain);
        t_pending p;
        p.item.token    = tok;
        p.item.distance = offs;
        p.drain         = drain;
        token_queue.push_back(p);
        if (tok <= TOKEN_LIT_MAX)
            gen_written = gen_written + 1;
        else if (tok < TOKEN_END)
            gen_written = gen_written + int'(tok) - int'(RUN_BIAS);
        if (gen_written > WIN_BYTES)
            gen_written = WIN_BYTES;
    endtask

    // expected beats for one accepted token
    task automatic expand_token(input t_in it);
        logic [WIN_BITS-1:0] src;
        logic [BYTE_W-1:0]   lane [LANES];
        int                  len;
        int                  fill;
        t_out                b;
        b = '0;
        if (it.token <= TOKEN_LIT_MAX) begin
            hist[wr_pos] = it.token[BYTE_W-1:0];
            wr_pos = wr_pos + WIN_BITS'(1);
            b.byte0      = it.token[BYTE_W-1:0];
            b.byte_count = 3'd1;
            b.last_beat  = 1'b1;
            beats_due.push_back(b);
        end else if (it.token == TOKEN_END) begin
            b.last_beat  = 1'b1;
            b.stream_end = 1'b1;
            beats_due.push_back(b);
        end else if (it.token < TOKEN_END) begin
            len  = int'(it.token) - int'(RUN_BIAS);
            src  = wr_pos - it.distance - WIN_BITS'(1);
            fill = 0;
            for (int i = 0; i < LANES; i++)
                lane[i] = '0;
            while (len > 0) begin
                // byte by byte so an overlapping copy sees its own output
                lane[fill] = hist[src];
                hist[wr_pos] = hist[src];
                wr_pos = wr_pos + WIN_BITS'(1);
                src = src + WIN_BITS'(1);
                fill++;
                len--;
                if (fill == LANES || len == 0) begin
                    b.byte0      = lane[0];
                    b.byte1      = lane[1];
                    b.byte2      = lane[2];
                    b.byte3      = lane[3];
                    b.byte_count = COUNT_W'(fill);
                    b.last_beat  = (len == 0);
                    b.stream_end = 1'b0;
                    beats_due.push_back(b);
                    fill = 0;
                    for (int i = 0; i < LANES; i++)
                        lane[i] = '0;
                end
            end
        end
    endtask

    // sender: one token offered at a time, random gaps after each transfer
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (src_gap > 0) begin
                i_in_valid <= 1'b0;
                src_gap <= src_gap - 1;
            end else if (token_queue.size() > 0 &&
                         !(token_queue[0].drain && beats_due.size() > 0)) begin
                i_in_data  <= token_queue[0].item;
                i_in_valid <= 1'b1;
                token_queue.pop_front();
                offered++;
                if ((offered / 40) % 3 == 0)
                    src_gap <= 0;
                else if ($urandom_range(99) < 70)
                    src_gap <= 0;
                else if ($urandom_range(99) < 75)
                    src_gap <= $urandom_range(3, 1);
                else
                    src_gap <= $urandom_range(40, 10);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus one long hold-off to back the block up
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (park_left > 0) begin
            i_out_ready <= 1'b0;
            park_left <= park_left - 1;
        end else if (!parked && taken_count >= PARK_AT) begin
            parked <= 1'b1;
            park_left <= PARK_CYCLES - 1;
            i_out_ready <= 1'b0;
        end else if (rdy_gap > 0) begin
            i_out_ready <= 1'b0;
            rdy_gap <= rdy_gap - 1;
        end else if ((cycles / 400) % 3 == 0 || $urandom_range(99) >= 15) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= 1'b0;
            rdy_gap <= ($urandom_range(9) == 0) ? $urandom_range(30, 10)
                                                 : $urandom_range(2, 0);
        end
    end

    // output check first, then prediction for a token taken on the same edge
    always @(posedge i_clk) begin
        in_taken <= i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (beats_due.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected beat at cycle %0d: %h %h %h %h cnt %0d last %0b end %0b",
                                 cycles, o_out_data.byte0, o_out_data.byte1,
                                 o_out_data.byte2, o_out_data.byte3,
                                 o_out_data.byte_count, o_out_data.last_beat,
                                 o_out_data.stream_end);
                end else begin
                    if (o_out_data.byte0 !== beats_due[0].byte0 ||
                        o_out_data.byte1 !== beats_due[0].byte1 ||
                        o_out_data.byte2 !== beats_due[0].byte2 ||
                        o_out_data.byte3 !== beats_due[0].byte3 ||
                        o_out_data.byte_count !== beats_due[0].byte_count ||
                        o_out_data.last_beat !== beats_due[0].last_beat ||
                        o_out_data.stream_end !== beats_due[0].stream_end) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("beat mismatch at cycle %0d", cycles);
                            $display("  expected %h %h %h %h cnt %0d last %0b end %0b",
                                     beats_due[0].byte0, beats_due[0].byte1,
                                     beats_due[0].byte2, beats_due[0].byte3,
                                     beats_due[0].byte_count, beats_due[0].last_beat,
                                     beats_due[0].stream_end);
                            $display("  actual   %h %h %h %h cnt %0d last %0b end %0b",
                                     o_out_data.byte0, o_out_data.byte1,
                                     o_out_data.byte2, o_out_data.byte3,
                                     o_out_data.byte_count, o_out_data.last_beat,
                                     o_out_data.stream_end);
                        end
                    end
                    beats_due.pop_front();
                end
            end
            if (i_in_valid && o_in_ready) begin
                expand_token(i_in_data);
                taken_count++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int n_rand;
        int len;
        int sel;
        int dmax;
        logic [DIST_W-1:0] offs;

        // directed tokens: literal extremes, short and long runs, overlap,
        // oldest byte, end markers back to back, the unused token
        queue_token(9'd0, 13'd0, 1'b0);
        queue_token(TOKEN_LIT_MAX, 13'h1FFF, 1'b0);
        queue_token(9'h041, 13'($urandom_range(8191)), 1'b0);
        queue_token(9'h05A, 13'($urandom_range(8191)), 1'b0);
        queue_token(9'h012, 13'($urandom_range(8191)), 1'b0);
        queue_token(9'h0C3, 13'($urandom_range(8191)), 1'b0);
        queue_token(TOKEN_RUN_MIN, 13'd0, 1'b0);
        queue_token(TOKEN_RUN_MIN + 9'd1, 13'd5, 1'b0);
        queue_token(TOKEN_RUN_MIN + 9'd2, 13'd1, 1'b0);
        queue_token(TOKEN_END, 13'($urandom_range(8191)), 1'b0);
        queue_token(9'h077, 13'($urandom_range(8191)), 1'b0);
        queue_token(TOKEN_NULL, 13'($urandom_range(8191)), 1'b0);
        queue_token(TOKEN_RUN_MIN + 9'd5, 13'd3, 1'b0);
        queue_token(TOKEN_RUN_MAX, 13'd0, 1'b0);
        queue_token(TOKEN_RUN_MAX, 13'(gen_written - 1), 1'b0);
        queue_token(TOKEN_RUN_MIN + 9'd3, 13'd2, 1'b0);
        queue_token(TOKEN_END, 13'h1FFF, 1'b0);
        queue_token(TOKEN_END, 13'd0, 1'b0);
        queue_token(9'h0A5, 13'($urandom_range(8191)), 1'b1);

        n_rand = 0;
        while (n_rand < RAND_ITEMS) begin
            sel = $urandom_range(99);
            if (sel < 30) begin
                queue_token(9'($urandom_range(255)), 13'($urandom_range(8191)),
                            n_rand == 100);
                n_rand++;
            end else if (sel < 34) begin
                queue_token(TOKEN_END, 13'($urandom_range(8191)), n_rand == 100);
                n_rand++;
            end else if (sel < 37) begin
                // dropped by the block, not counted
                queue_token(TOKEN_NULL, 13'($urandom_range(8191)), 1'b0);
            end else begin
                sel = $urandom_range(9);
                if (sel < 4)
                    len = $urandom_range(16, 3);
                else if (sel < 7)
                    len = $urandom_range(200, 17);
                else
                    len = $urandom_range(256, 201);
                // only reach back into bytes already written since reset
                dmax = gen_written - 1;
                sel = $urandom_range(2);
                if (sel == 0)
                    offs = 13'($urandom_range((dmax < 7) ? dmax : 7, 0));
                else if (sel == 1 || dmax < 64)
                    offs = 13'($urandom_range(dmax, 0));
                else
                    offs = 13'($urandom_range(dmax, dmax - 63));
                queue_token(9'(int'(RUN_BIAS) + len), offs, n_rand == 100);
                n_rand++;
            end
        end

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (token_queue.size() > 0 || i_in_valid)
            @(posedge i_clk);
        while (beats_due.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        if (errors == 0 && beats_due.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/lzwce_pkg.sv
hw/rtl/lzwce_window_ram.sv
hw/rtl/lzwce_beat_packer.sv
hw/rtl/lz_window_copy_expander_core.sv
bench/tb.sv
